// ===== src/mwlfo_pkg.sv =====
`default_nettype none

package mwlfo_pkg;

   // Default sizes for the top-level parameters
   localparam int PHASE_BITS_DEF      = 24;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // Fixed port widths
   localparam int CV_BITS       = 16;
   localparam int OUT_BITS      = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int DEPTH_BITS    = 17;
   localparam int WAVE_BITS     = 3;

   // Register indexes on the csr port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_BASE_INC    = 2'd0,
      CSR_DEPTH       = 2'd1,
      CSR_WAVEFORM    = 2'd2,
      CSR_START_PHASE = 2'd3
   } csr_index_type;

   // Waveform select codes; the remaining codes give silence
   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_SAW      = 3'd2,
      WAVE_SQUARE   = 3'd3,
      WAVE_HOLD     = 3'd4
   } wave_type;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] BASE_INC_RESET    = 24'd16777;
   localparam logic [DEPTH_BITS-1:0]    DEPTH_RESET       = 17'd65536;
   localparam logic [CSR_DATA_BITS-1:0] START_PHASE_RESET = 24'd0;

   // Noise generator: Galois, right shift
   localparam logic [31:0] LFSR_SEED = 32'h2545_F491;
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

   // 2^(k/16) in Q2.16, k = 0..16
   localparam logic [17:0] EXP2_TAB [17] = '{
      18'd65536,  18'd68438,  18'd71468,  18'd74632,
      18'd77936,  18'd81386,  18'd84990,  18'd88752,
      18'd92682,  18'd96785,  18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515,
      18'd131072
   };

   // Quarter-wave sine magnitude for table entry idx, evaluated at elaboration
   function automatic longint sine_mag(input int idx, input int stb, input int sb);
      longint x;
      longint x2;
      longint t;
      longint y;
      x  = longint'(idx) << (18 - stb);
      x2 = (x * x) >>> 16;
      t  = 42047 - ((4640 * x2) >>> 16);
      t  = 102944 - ((t * x2) >>> 16);
      y  = (x * t) >>> 16;
      if (y > 65536) begin
         y = 65536;
      end
      return (y << (sb - 1)) >>> 16;
   endfunction

endpackage

`default_nettype wire

// ===== src/multiwave_lfo_with_sync_unit.sv =====
// Multi-waveform LFO with hard sync.
// Request channel (req_valid/req_ready): one request per sample tick, carrying
// the sync gate level and the rate CV (signed Q4.12 octaves). Response channel
// (rsp_valid/rsp_ready): one Q1.15 output sample per request, in order.
// csr port: write enable, index and data; base increment, depth, waveform and
// start phase. Write only while no request is in flight.
// The response passes through five register stages (input, exp2 mantissa,
// phase step, waveform, gain). Throughput: one request per cycle while the
// receiver takes responses; the phase accumulator loop closes in a single
// stage, so consecutive requests follow each other without a gap.
// A stalled receiver holds the response register; the stages behind it fill
// up and req_ready drops only once every stage holds a request.
// Reset (synchronous) empties the pipeline, restores the register defaults,
// loads the phase from the start phase default, clears the held sample and
// the sync history, and seeds the noise generator.
`default_nettype none

module multiwave_lfo_with_sync_unit #(
   parameter int PHASE_BITS      = mwlfo_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = mwlfo_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = mwlfo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_sync_gate,
   input  logic signed [mwlfo_pkg::CV_BITS-1:0] req_rate_cv,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mwlfo_pkg::OUT_BITS-1:0] rsp_cv_out,
   input  logic                                 csr_we,
   input  logic [mwlfo_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [mwlfo_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mwlfo_pkg::*;

   localparam int PB      = PHASE_BITS;
   localparam int SB      = SAMPLE_BITS;
   localparam int RS_BASE = 40 - PHASE_BITS;
   localparam int PW      = SB + 19;
   localparam logic [40:0]        HALF_WIDE = 41'(1) << (PB - 1);
   localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((2 ** SAMPLE_BITS) - 1);

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] base_inc_ff;
   logic [DEPTH_BITS-1:0]    depth_ff;
   logic [WAVE_BITS-1:0]     waveform_ff;
   logic [CSR_DATA_BITS-1:0] start_phase_ff;

   // Stage valids and flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic adv2, adv3, adv4, adv5;
   logic fire3;

   // Stage 1: captured request
   logic                      s1_sync_ff;
   logic signed [CV_BITS-1:0] s1_cv_ff;
   logic [3:0]                seg_lo;
   logic [4:0]                seg_hi;
   logic [12:0]               seg_diff;
   logic [20:0]               frac_prod;
   logic [16:0]               mant_in;

   // Stage 2: mantissa and octave
   logic [16:0]       s2_mant_ff;
   logic signed [3:0] s2_oct_ff;
   logic              s2_sync_ff;
   logic [40:0]       scaled;
   logic [5:0]        shift_amt;
   logic [40:0]       shifted;
   logic [PB-1:0]     dt_in;

   // Stage 3: phase step and oscillator state
   logic [PB-1:0]          s3_dt_ff;
   logic                   s3_sync_ff;
   logic [PB-1:0]          phase_acc_ff, phase_acc_in;
   logic signed [SB-1:0]   held_ff, held_in;
   logic                   last_sync_ff;
   logic [31:0]            lfsr_ff, lfsr_in, lfsr_step;
   logic [PB+23:0]         start_wide;
   logic [PB-1:0]          cur_phase;
   logic                   take_sample;
   logic signed [SB:0]     wave_val;

   // Stage 4: waveform value; output register
   logic signed [SB:0]       s4_val_ff;
   logic signed [PW-1:0]     prod;
   logic signed [PW-1:0]     biased;
   logic signed [18:0]       quo;
   logic signed [OUT_BITS-1:0] cv_out_in;
   logic signed [OUT_BITS-1:0] rsp_cv_out_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_inc_ff    <= BASE_INC_RESET;
         depth_ff       <= DEPTH_RESET;
         waveform_ff    <= WAVE_SINE;
         start_phase_ff <= START_PHASE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BASE_INC:    base_inc_ff    <= csr_wdata;
            CSR_DEPTH:       depth_ff       <= csr_wdata[DEPTH_BITS-1:0];
            CSR_WAVEFORM:    waveform_ff    <= csr_wdata[WAVE_BITS-1:0];
            CSR_START_PHASE: start_phase_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance a stage when the one ahead is empty or moving
   assign adv5      = !rsp_valid_ff || rsp_ready;
   assign adv4      = !s4_valid_ff || adv5;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign req_ready = !s1_valid_ff || adv2;
   assign fire3     = s3_valid_ff && adv4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff  <= req_valid;
         if (adv2)      s2_valid_ff  <= s1_valid_ff;
         if (adv3)      s3_valid_ff  <= s2_valid_ff;
         if (adv4)      s4_valid_ff  <= s3_valid_ff;
         if (adv5)      rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: hold the request
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_sync_ff <= req_sync_gate;
         s1_cv_ff   <= req_rate_cv;
      end
   end

   // Interpolate 2^frac from the sixteenth-octave table
   assign seg_lo    = s1_cv_ff[11:8];
   assign seg_hi    = {1'b0, seg_lo} + 5'd1;
   assign seg_diff  = 13'(EXP2_TAB[seg_hi] - EXP2_TAB[{1'b0, seg_lo}]);
   assign frac_prod = seg_diff * s1_cv_ff[7:0];
   assign mant_in   = 17'(EXP2_TAB[{1'b0, seg_lo}] + 18'(frac_prod[20:8]));

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_mant_ff <= mant_in;
         s2_oct_ff  <= s1_cv_ff[15:12];
         s2_sync_ff <= s1_sync_ff;
      end
   end

   // Stage 2: scale the base step by the mantissa and octave, clamp to half a cycle
   assign scaled    = base_inc_ff * s2_mant_ff;
   assign shift_amt = 6'(RS_BASE) - {{2{s2_oct_ff[3]}}, s2_oct_ff};
   assign shifted   = scaled >> shift_amt;
   assign dt_in     = (shifted > HALF_WIDE) ? HALF_WIDE[PB-1:0] : shifted[PB-1:0];

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_dt_ff   <= dt_in;
         s3_sync_ff <= s2_sync_ff;
      end
   end

   // Stage 3: reload on a sync rising edge, pick the sample, advance the phase
   assign start_wide  = {start_phase_ff, {PB{1'b0}}};
   assign cur_phase   = (s3_sync_ff && !last_sync_ff) ? start_wide[PB+23:24] : phase_acc_ff;
   assign lfsr_step   = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 32'd0);
   assign take_sample = (waveform_ff == WAVE_HOLD) && (cur_phase < s3_dt_ff);
   assign lfsr_in     = take_sample ? lfsr_step : lfsr_ff;
   assign held_in     = take_sample ? $signed(lfsr_step[31 -: SB]) : held_ff;
   assign phase_acc_in = cur_phase + s3_dt_ff;

   mwlfo_wave #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave (
      .phase    (cur_phase),
      .waveform (waveform_ff),
      .held     (held_in),
      .wave_out (wave_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= start_wide[PB+23:24] & '0;
         held_ff      <= '0;
         last_sync_ff <= 1'b0;
         lfsr_ff      <= LFSR_SEED;
      end else if (fire3) begin
         phase_acc_ff <= phase_acc_in;
         held_ff      <= held_in;
         last_sync_ff <= s3_sync_ff;
         lfsr_ff      <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_val_ff <= wave_val;
      end
   end

   // Stage 4: apply depth, truncate toward zero, saturate
   assign prod   = s4_val_ff * $signed({1'b0, depth_ff});
   assign biased = prod + (prod[PW-1] ? TRUNC_BIAS : '0);
   assign quo    = biased[SB+18:SB];

   always_comb begin
      if (quo > 19'sd32767) begin
         cv_out_in = 16'sh7FFF;
      end else if (quo < -19'sd32768) begin
         cv_out_in = -16'sh8000;
      end else begin
         cv_out_in = quo[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         rsp_cv_out_ff <= cv_out_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cv_out = rsp_cv_out_ff;

endmodule

`default_nettype wire

// ===== src/mwlfo_wave.sv =====
`default_nettype none

module mwlfo_wave #(
   parameter int PHASE_BITS      = mwlfo_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = mwlfo_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = mwlfo_pkg::SAMPLE_BITS_DEF
) (
   input  logic [PHASE_BITS-1:0]          phase,
   input  logic [mwlfo_pkg::WAVE_BITS-1:0] waveform,
   input  logic signed [SAMPLE_BITS-1:0]  held,
   output logic signed [SAMPLE_BITS:0]    wave_out
);
   import mwlfo_pkg::*;

   localparam int QUARTER  = 2 ** (SINE_TABLE_BITS - 2);
   localparam int IDX_BITS = SINE_TABLE_BITS - 1;
   localparam int VW       = SAMPLE_BITS + 2;
   localparam logic signed [VW-1:0] FULL_SCALE = VW'(2 ** (SAMPLE_BITS - 1));
   localparam logic signed [VW-1:0] THREE_FS   = VW'(3 * (2 ** (SAMPLE_BITS - 1)));

   logic [SAMPLE_BITS-1:0]        sine_rom [QUARTER+1];
   logic [SINE_TABLE_BITS-1:0]    sine_k;
   logic [1:0]                    quad;
   logic [SINE_TABLE_BITS-3:0]    quad_pos;
   logic [IDX_BITS-1:0]           rom_idx;
   logic [SAMPLE_BITS-1:0]        sine_abs;
   logic signed [VW-1:0]          sine_val;
   logic [PHASE_BITS+SAMPLE_BITS:0]   tri_wide;
   logic [SAMPLE_BITS:0]              tri_s;
   logic signed [VW-1:0]              tri_val;
   logic [PHASE_BITS+SAMPLE_BITS-1:0] saw_wide;
   logic [SAMPLE_BITS-1:0]            saw_s;
   logic signed [VW-1:0]              saw_val;
   logic signed [VW-1:0]              sq_val;
   logic signed [VW-1:0]              sel_val;

   // Quarter-wave sine table, one entry past the quarter for the peak
   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      assign sine_rom[g] = SAMPLE_BITS'(sine_mag(g, SINE_TABLE_BITS, SAMPLE_BITS));
   end

   // Fold the phase into one quarter and mirror as needed
   assign sine_k   = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign quad     = sine_k[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
   assign quad_pos = sine_k[SINE_TABLE_BITS-3:0];
   assign rom_idx  = quad[0] ? (IDX_BITS'(QUARTER) - {1'b0, quad_pos}) : {1'b0, quad_pos};
   assign sine_abs = sine_rom[rom_idx];
   assign sine_val = quad[1] ? -$signed({2'b00, sine_abs}) : $signed({2'b00, sine_abs});

   // Triangle rises over the first half and falls over the second
   assign tri_wide = {phase, {(SAMPLE_BITS+1){1'b0}}};
   assign tri_s    = tri_wide[PHASE_BITS+SAMPLE_BITS:PHASE_BITS];
   assign tri_val  = phase[PHASE_BITS-1] ? (THREE_FS - $signed({1'b0, tri_s}))
                                         : ($signed({1'b0, tri_s}) - FULL_SCALE);

   // Saw ramps from minus to plus full scale
   assign saw_wide = {phase, {SAMPLE_BITS{1'b0}}};
   assign saw_s    = saw_wide[PHASE_BITS+SAMPLE_BITS-1:PHASE_BITS];
   assign saw_val  = $signed({2'b00, saw_s}) - FULL_SCALE;

   assign sq_val = phase[PHASE_BITS-1] ? -FULL_SCALE : FULL_SCALE;

   // Pick the shape
   always_comb begin
      case (waveform)
         WAVE_SINE:     sel_val = sine_val;
         WAVE_TRIANGLE: sel_val = tri_val;
         WAVE_SAW:      sel_val = saw_val;
         WAVE_SQUARE:   sel_val = sq_val;
         WAVE_HOLD:     sel_val = {{2{held[SAMPLE_BITS-1]}}, held};
         default:       sel_val = '0;
      endcase
   end

   assign wave_out = sel_val[SAMPLE_BITS:0];

endmodule

`default_nettype wire

// ===== src/mwlfo_chk.sv =====
`default_nettype none

module mwlfo_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [mwlfo_pkg::OUT_BITS-1:0] rsp_cv_out
);
   import mwlfo_pkg::*;

   localparam logic [2:0] PIPE_DEPTH = 3'd5;

   logic [2:0] pending_ff, pending_in;
   logic       take_req;
   logic       give_rsp;

   // Track requests taken but not yet answered
   assign take_req   = req_valid && req_ready;
   assign give_rsp   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + {2'b00, take_req} - {2'b00, give_rsp};

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cv_out))
      else $error("stalled response changed");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Back-pressure only when the output is stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without a stalled response");

   // No response without a request in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without a request");

   // Never more in flight than pipeline stages
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PIPE_DEPTH)
      else $error("too many requests in flight");

endmodule

bind multiwave_lfo_with_sync_unit mwlfo_chk u_chk (.*);

`default_nettype wire
